/* hw/rtl/av_sync_frame_pacer_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the frame pacer
// Shared property wrappers; every check is sampled on clk and idle in reset.
// ----------------------------------------------------------------------------
`ifndef AV_SYNC_FRAME_PACER_MACROS_SVH
`define AV_SYNC_FRAME_PACER_MACROS_SVH

// Condition holds at every sampled edge
`define AFP_ASSERT_HOLDS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define AFP_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define AFP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/afp_pkg.sv */
// ----------------------------------------------------------------------------
// afp_pkg
// Widths, register map, reset values and shared types of the frame pacer.
// ----------------------------------------------------------------------------
package afp_pkg;

    // Field and state widths
    localparam int PTS_W    = 40;
    localparam int MCLK_W   = 41;
    localparam int TIMER_W  = 42;
    localparam int IVL_W    = 24;
    localparam int THR_W    = 20;
    localparam int NOSYNC_W = 27;
    localparam int GAP_W    = 24;
    localparam int DLY_W    = 20;
    localparam int MS_W     = 16;

    // APB port
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int RIDX_W   = 3;

    // Microsecond to millisecond conversion: floor(x * RECIP / 2^SHIFT)
    // is exact for x below 2^26.
    localparam int X_W         = 26;
    localparam int RECIP_W     = 27;
    localparam int PROD_W      = X_W + RECIP_W;
    localparam int DELAY_SHIFT = 36;
    localparam logic [RECIP_W-1:0] DELAY_RECIP = 27'd68719477;
    localparam logic [X_W-1:0]     ROUND_US    = 26'd500;
    // at or above this delay the rounded value exceeds 65535 ms
    localparam logic [X_W-1:0]     SAT_US      = 26'd65535500;

    // Register indexes
    localparam logic [RIDX_W-1:0] REG_MIN_SYNC  = 3'd0;
    localparam logic [RIDX_W-1:0] REG_MAX_SYNC  = 3'd1;
    localparam logic [RIDX_W-1:0] REG_NO_SYNC   = 3'd2;
    localparam logic [RIDX_W-1:0] REG_MAX_GAP   = 3'd3;
    localparam logic [RIDX_W-1:0] REG_MIN_DELAY = 3'd4;

    // Register reset values
    localparam logic [THR_W-1:0]    MIN_SYNC_RST  = 20'd40000;
    localparam logic [THR_W-1:0]    MAX_SYNC_RST  = 20'd100000;
    localparam logic [NOSYNC_W-1:0] NO_SYNC_RST   = 27'd10000000;
    localparam logic [GAP_W-1:0]    MAX_GAP_RST   = 24'd1000000;
    localparam logic [DLY_W-1:0]    MIN_DELAY_RST = 20'd10000;

    // Outcome of one refresh event
    typedef enum logic [1:0] {
        RES_END,
        RES_DROP,
        RES_RENDER
    } result_kind_t;

    typedef struct packed {
        logic [THR_W-1:0]    min_sync;
        logic [THR_W-1:0]    max_sync;
        logic [NOSYNC_W-1:0] no_sync;
        logic [GAP_W-1:0]    max_gap;
        logic [DLY_W-1:0]    min_delay;
    } afp_cfg_t;

    // Decision stage to delay stage
    typedef struct packed {
        result_kind_t         kind;
        logic [TIMER_W-1:0]   display_timer;
        logic [PTS_W-1:0]     now;
    } afp_dec_t;

endpackage

/* hw/rtl/afp_cfg_regs.sv */
// ----------------------------------------------------------------------------
// afp_cfg_regs
// APB register file holding the sync thresholds, gap limit and delay floor.
// ----------------------------------------------------------------------------
module afp_cfg_regs
    import afp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output afp_cfg_t           cfg
);

    logic [THR_W-1:0]    min_sync_reg;
    logic [THR_W-1:0]    max_sync_reg;
    logic [NOSYNC_W-1:0] no_sync_reg;
    logic [GAP_W-1:0]    max_gap_reg;
    logic [DLY_W-1:0]    min_delay_reg;
    logic [RIDX_W-1:0]   reg_idx;
    logic                wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_sync_reg  <= MIN_SYNC_RST;
            max_sync_reg  <= MAX_SYNC_RST;
            no_sync_reg   <= NO_SYNC_RST;
            max_gap_reg   <= MAX_GAP_RST;
            min_delay_reg <= MIN_DELAY_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_MIN_SYNC:  min_sync_reg  <= pwdata[THR_W-1:0];
                REG_MAX_SYNC:  max_sync_reg  <= pwdata[THR_W-1:0];
                REG_NO_SYNC:   no_sync_reg   <= pwdata[NOSYNC_W-1:0];
                REG_MAX_GAP:   max_gap_reg   <= pwdata[GAP_W-1:0];
                REG_MIN_DELAY: min_delay_reg <= pwdata[DLY_W-1:0];
                default:       ;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        case (reg_idx)
            REG_MIN_SYNC:  prdata = {{(PDATA_W-THR_W){1'b0}}, min_sync_reg};
            REG_MAX_SYNC:  prdata = {{(PDATA_W-THR_W){1'b0}}, max_sync_reg};
            REG_NO_SYNC:   prdata = {{(PDATA_W-NOSYNC_W){1'b0}}, no_sync_reg};
            REG_MAX_GAP:   prdata = {{(PDATA_W-GAP_W){1'b0}}, max_gap_reg};
            REG_MIN_DELAY: prdata = {{(PDATA_W-DLY_W){1'b0}}, min_delay_reg};
            default:       prdata = '0;
        endcase
    end

    assign cfg.min_sync  = min_sync_reg;
    assign cfg.max_sync  = max_sync_reg;
    assign cfg.no_sync   = no_sync_reg;
    assign cfg.max_gap   = max_gap_reg;
    assign cfg.min_delay = min_delay_reg;

endmodule

/* hw/rtl/afp_decide.sv */
// ----------------------------------------------------------------------------
// afp_decide
// Input register, pacing state, result register and the end/drop/double/keep decision per event.
// ----------------------------------------------------------------------------
`include "av_sync_frame_pacer_macros.svh"

module afp_decide
    import afp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  afp_cfg_t                 cfg,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     frame_present,
    input  logic [PTS_W-1:0]         frame_pts_us,
    input  logic signed [MCLK_W-1:0] master_clock_us,
    input  logic                     master_clock_valid,
    input  logic [PTS_W-1:0]         now_us,
    output logic                     dec_valid,
    input  logic                     dec_ready,
    output afp_dec_t                 dec
);

    // Input register
    logic               s1_valid_reg;
    logic               s1_present_reg;
    logic [PTS_W-1:0]   s1_pts_reg;
    logic [MCLK_W-1:0]  s1_master_reg;
    logic               s1_clk_ok_reg;
    logic [PTS_W-1:0]   s1_now_reg;

    // Pacing state
    logic [PTS_W-1:0]   last_pts_reg;
    logic [IVL_W-1:0]   last_interval_reg;
    logic [TIMER_W-1:0] display_timer_reg;
    logic [PTS_W-1:0]   last_pts_next;
    logic [IVL_W-1:0]   last_interval_next;
    logic [TIMER_W-1:0] display_timer_next;

    // Result register
    logic               s2_valid_reg;
    afp_dec_t           dec_reg;
    afp_dec_t           dec_next;

    logic               s2_ready;
    logic               s1_fire;

    logic [PTS_W:0]     gap;
    logic               gap_ok;
    logic [IVL_W-1:0]   interval;
    logic [THR_W-1:0]   thr_cap;
    logic [THR_W-1:0]   thr;
    logic [MCLK_W:0]    diff;
    logic [MCLK_W:0]    neg_diff;
    logic [MCLK_W-1:0]  adiff;
    logic               diff_neg;
    logic               diff_zero;
    logic               past_thr;
    logic               in_sync;
    logic               late;
    logic               early;
    logic [IVL_W:0]     step;
    logic [TIMER_W:0]   timer_sum;
    logic [TIMER_W-1:0] timer_adv;
    result_kind_t       kind_next;

    // Handshake
    assign s2_ready  = !s2_valid_reg || dec_ready;
    assign s1_fire   = s1_valid_reg && s2_ready;
    assign in_ready  = !s1_valid_reg || s2_ready;
    assign dec_valid = s2_valid_reg;
    assign dec       = dec_reg;

    // Frame interval, falling back to the last one on a bad gap
    assign gap    = {1'b0, s1_pts_reg} - {1'b0, last_pts_reg};
    assign gap_ok = (last_pts_reg != '0) && !gap[PTS_W] && (gap != '0)
                    && (gap[PTS_W-1:0] < {{(PTS_W-GAP_W){1'b0}}, cfg.max_gap});
    assign interval = gap_ok ? gap[IVL_W-1:0] : last_interval_reg;

    // Sync threshold; the minimum wins over the maximum
    assign thr_cap = (interval < {{(IVL_W-THR_W){1'b0}}, cfg.max_sync})
                     ? interval[THR_W-1:0] : cfg.max_sync;
    assign thr     = (thr_cap < cfg.min_sync) ? cfg.min_sync : thr_cap;

    // Distance to master clock
    assign diff      = {2'b00, s1_pts_reg} - {s1_master_reg[MCLK_W-1], s1_master_reg};
    assign neg_diff  = '0 - diff;
    assign diff_neg  = diff[MCLK_W];
    assign diff_zero = (diff == '0);
    assign adiff     = diff_neg ? neg_diff[MCLK_W-1:0] : diff[MCLK_W-1:0];
    assign past_thr  = adiff >= {{(MCLK_W-THR_W){1'b0}}, thr};
    assign in_sync   = s1_clk_ok_reg
                       && (adiff < {{(MCLK_W-NOSYNC_W){1'b0}}, cfg.no_sync});
    assign late      = in_sync && (diff_neg || diff_zero) && past_thr;
    assign early     = in_sync && !diff_neg && past_thr;

    // Display timer advance, doubled when video runs ahead, saturating
    assign step      = early ? {interval, 1'b0} : {1'b0, interval};
    assign timer_sum = {1'b0, display_timer_reg}
                       + {{(TIMER_W-IVL_W){1'b0}}, step};
    assign timer_adv = timer_sum[TIMER_W] ? {TIMER_W{1'b1}} : timer_sum[TIMER_W-1:0];

    // Outcome and next state
    always_comb
    begin
        if (!s1_present_reg)
            kind_next = RES_END;
        else if (late)
            kind_next = RES_DROP;
        else
            kind_next = RES_RENDER;

        last_pts_next      = last_pts_reg;
        last_interval_next = last_interval_reg;
        display_timer_next = display_timer_reg;
        if (s1_fire && s1_present_reg)
        begin
            last_pts_next      = s1_pts_reg;
            last_interval_next = interval;
            if (kind_next == RES_RENDER)
                display_timer_next = timer_adv;
        end

        dec_next.kind          = kind_next;
        dec_next.display_timer = timer_adv;
        dec_next.now           = s1_now_reg;
    end

    // Control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            last_pts_reg      <= '0;
            last_interval_reg <= '0;
            display_timer_reg <= '0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                s2_valid_reg <= s1_valid_reg;
            last_pts_reg      <= last_pts_next;
            last_interval_reg <= last_interval_next;
            display_timer_reg <= display_timer_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_present_reg <= frame_present;
            s1_pts_reg     <= frame_pts_us;
            s1_master_reg  <= master_clock_us;
            s1_clk_ok_reg  <= master_clock_valid;
            s1_now_reg     <= now_us;
        end
        if (s1_fire)
            dec_reg <= dec_next;
    end

    // Checks
    `AFP_ASSERT_HOLDS(a_timer_monotonic, display_timer_reg >= $past(display_timer_reg), "display timer moved backward")
    `AFP_ASSERT_NEXT(a_drop_keeps_timer, s1_fire && (kind_next == RES_DROP), $stable(display_timer_reg), "dropped frame advanced display timer")
    `AFP_ASSERT_NEXT(a_end_keeps_state, s1_fire && !s1_present_reg, $stable(last_pts_reg) && $stable(last_interval_reg), "end of play touched interval state")

endmodule

/* hw/rtl/afp_delay.sv */
// ----------------------------------------------------------------------------
// afp_delay
// Wake-up delay: floor, saturation and rounded microsecond to millisecond.
// ----------------------------------------------------------------------------
`include "av_sync_frame_pacer_macros.svh"

module afp_delay
    import afp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [DLY_W-1:0] min_delay,
    input  logic             dec_valid,
    output logic             dec_ready,
    input  afp_dec_t         dec,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             end_of_play,
    output logic             drop_frame,
    output logic             render_frame,
    output logic [MS_W-1:0]  next_delay_ms
);

    // Stage 3: clamped delay plus rounding
    logic              s3_valid_reg;
    result_kind_t      s3_kind_reg;
    logic              s3_sat_reg;
    logic [X_W-1:0]    s3_x_reg;

    // Stage 4: result register
    logic              s4_valid_reg;
    result_kind_t      s4_kind_reg;
    logic [MS_W-1:0]   s4_ms_reg;

    logic              s3_ready;
    logic              s4_ready;
    logic [TIMER_W:0]  act;
    logic              below_min;
    logic              at_sat;
    logic [X_W-1:0]    x_next;
    logic [PROD_W-1:0] prod;
    logic [MS_W-1:0]   ms_next;

    // Handshake
    assign s4_ready  = !s4_valid_reg || out_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign dec_ready = s3_ready;
    assign out_valid = s4_valid_reg;

    // Time until the display timer, floored and checked for saturation
    assign act       = {1'b0, dec.display_timer} - {{(TIMER_W-PTS_W+1){1'b0}}, dec.now};
    assign below_min = act[TIMER_W]
                       || (act[TIMER_W-1:0] < {{(TIMER_W-DLY_W){1'b0}}, min_delay});
    assign at_sat    = !act[TIMER_W]
                       && (act[TIMER_W-1:0] >= {{(TIMER_W-X_W){1'b0}}, SAT_US});
    assign x_next    = below_min ? ({{(X_W-DLY_W){1'b0}}, min_delay} + ROUND_US)
                                 : (act[X_W-1:0] + ROUND_US);

    // Divide by 1000 through the reciprocal
    assign prod = {{RECIP_W{1'b0}}, s3_x_reg} * {{X_W{1'b0}}, DELAY_RECIP};

    always_comb
    begin
        if (s3_kind_reg != RES_RENDER)
            ms_next = '0;
        else if (s3_sat_reg)
            ms_next = {MS_W{1'b1}};
        else
            ms_next = prod[DELAY_SHIFT+MS_W-1:DELAY_SHIFT];
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            if (s3_ready)
                s3_valid_reg <= dec_valid;
            if (s4_ready)
                s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (s3_ready)
        begin
            s3_kind_reg <= dec.kind;
            s3_sat_reg  <= at_sat;
            s3_x_reg    <= x_next;
        end
        if (s4_ready)
        begin
            s4_kind_reg <= s3_kind_reg;
            s4_ms_reg   <= ms_next;
        end
    end

    // Outcome flags
    always_comb
    begin
        end_of_play  = 1'b0;
        drop_frame   = 1'b0;
        render_frame = 1'b0;
        case (s4_kind_reg)
            RES_END:    end_of_play  = 1'b1;
            RES_DROP:   drop_frame   = 1'b1;
            RES_RENDER: render_frame = 1'b1;
            default:    ;
        endcase
    end
    assign next_delay_ms = s4_ms_reg;

    // Checks
    `AFP_ASSERT_IMPLIES(a_one_outcome, out_valid, $onehot({end_of_play, drop_frame, render_frame}), "result flags not one-hot")
    `AFP_ASSERT_IMPLIES(a_idle_delay_zero, out_valid && !render_frame, next_delay_ms == '0, "nonzero delay without render")
    `AFP_ASSERT_NEXT(a_sat_full, s4_ready && s3_valid_reg && (s3_kind_reg == RES_RENDER) && s3_sat_reg, next_delay_ms == {MS_W{1'b1}}, "saturated delay not at full scale")

endmodule

/* hw/rtl/av_sync_frame_pacer.sv */
// Path: input register, decision register, delay stage 3 and stage 4 registers.
// Throughput: one transaction per cycle unless stalled; pacing state updates per decision.
// Back-pressure on the output stalls all stages; ready follows free slots.
// Reset (rst_n low, async): pipeline empty, state zero, registers at defaults.
// ----------------------------------------------------------------------------
// av_sync_frame_pacer
// Audio/video sync pacer: decides drop, render or end of play per refresh
// event and schedules the next wake-up in milliseconds.
// ----------------------------------------------------------------------------
module av_sync_frame_pacer
    import afp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready,
    // refresh events
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     frame_present,
    input  logic [PTS_W-1:0]         frame_pts_us,
    input  logic signed [MCLK_W-1:0] master_clock_us,
    input  logic                     master_clock_valid,
    input  logic [PTS_W-1:0]         now_us,
    // results
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     end_of_play,
    output logic                     drop_frame,
    output logic                     render_frame,
    output logic [MS_W-1:0]          next_delay_ms
);

    afp_cfg_t cfg;
    afp_dec_t dec;
    logic     dec_valid;
    logic     dec_ready;

    // Register file
    afp_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Decision and pacing state
    afp_decide u_decide (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg                (cfg),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .frame_present      (frame_present),
        .frame_pts_us       (frame_pts_us),
        .master_clock_us    (master_clock_us),
        .master_clock_valid (master_clock_valid),
        .now_us             (now_us),
        .dec_valid          (dec_valid),
        .dec_ready          (dec_ready),
        .dec                (dec)
    );

    // Wake-up delay
    afp_delay u_delay (
        .clk           (clk),
        .rst_n         (rst_n),
        .min_delay     (cfg.min_delay),
        .dec_valid     (dec_valid),
        .dec_ready     (dec_ready),
        .dec           (dec),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .end_of_play   (end_of_play),
        .drop_frame    (drop_frame),
        .render_frame  (render_frame),
        .next_delay_ms (next_delay_ms)
    );

endmodule

/* verif/tb_av_sync_frame_pacer.sv */
// ----------------------------------------------------------------------------
// tb_av_sync_frame_pacer
// Self-checking bench for the A/V frame pacer. Refresh events go in over a
// valid/ready channel, and each decision that comes out is compared field by
// field against a cycle-free model of the pacing rules kept in this file.
// Directed events cover the gap, threshold, drop/double and delay rounding
// corners. Random phases then run frame streams under several register
// settings, with random stalls on both channels, and a last phase with both sides always ready.
// ----------------------------------------------------------------------------
module tb_av_sync_frame_pacer;
    import afp_pkg::*;

    localparam int     PIPE_LATENCY = 3;
    localparam int     CYCLE_LIMIT  = 400000;
    localparam int     MAX_REPORTS  = 10;
    localparam longint PTS_MAX      = (longint'(1) <<< PTS_W) - 1;
    localparam longint MCLK_MIN     = -(longint'(1) <<< (MCLK_W - 1));
    localparam longint TIMER_MAX    = (longint'(1) <<< TIMER_W) - 1;
    localparam longint MS_MAX       = (longint'(1) <<< MS_W) - 1;
    localparam longint US_PER_MS    = 1000;
    localparam longint HALF_MS_US   = 500;

    // One refresh event and the decision it produces
    typedef struct {
        logic                     present;
        logic [PTS_W-1:0]         pts;
        logic signed [MCLK_W-1:0] mclk;
        logic                     mclk_ok;
        logic [PTS_W-1:0]         now;
    } refresh_t;

    typedef struct {
        logic            eop;
        logic            drop;
        logic            render;
        logic [MS_W-1:0] ms;
    } decision_t;

    logic                     clk;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;
    logic                     in_valid;
    logic                     in_ready;
    logic                     frame_present;
    logic [PTS_W-1:0]         frame_pts_us;
    logic signed [MCLK_W-1:0] master_clock_us;
    logic                     master_clock_valid;
    logic [PTS_W-1:0]         now_us;
    logic                     out_valid;
    logic                     out_ready;
    logic                     end_of_play;
    logic                     drop_frame;
    logic                     render_frame;
    logic [MS_W-1:0]          next_delay_ms;

    // Pacing model state and register shadow
    afp_cfg_t         cfg_model;
    logic [PTS_W-1:0] last_pts_q;
    longint           last_ivl_q;
    logic [TIMER_W-1:0] timer_q;

    decision_t expected_decisions[$];
    int        mismatch_count;
    int        cycle_count;
    int        rx_hold;
    bit        tx_idle_en = 1'b1;
    bit        rx_idle_en = 1'b1;

    av_sync_frame_pacer dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready),
        .in_valid           (in_valid),
        .in_ready           (in_ready),
        .frame_present      (frame_present),
        .frame_pts_us       (frame_pts_us),
        .master_clock_us    (master_clock_us),
        .master_clock_valid (master_clock_valid),
        .now_us             (now_us),
        .out_valid          (out_valid),
        .out_ready          (out_ready),
        .end_of_play        (end_of_play),
        .drop_frame         (drop_frame),
        .render_frame       (render_frame),
        .next_delay_ms      (next_delay_ms)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run-length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic void report_error(string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // Pacing decision for one event; updates the model state
    function automatic decision_t pace_event(refresh_t ev);
        decision_t    d;
        result_kind_t kind;
        longint       ivl;
        longint       mclk;
        longint       diff;
        longint       adiff;
        longint       thr;
        longint       tmr;
        longint       act;
        longint       ms;
        kind = RES_RENDER;
        ms   = 0;
        if (!ev.present)
            kind = RES_END;
        else
        begin
            // frame interval, falling back to the previous one on a bad gap
            ivl = (last_pts_q == '0) ? 0 : longint'(ev.pts) - longint'(last_pts_q);
            if (ivl <= 0 || ivl >= longint'(cfg_model.max_gap))
                ivl = last_ivl_q;
            last_ivl_q = ivl;
            last_pts_q = ev.pts;

            mclk  = {{(64-MCLK_W){ev.mclk[MCLK_W-1]}}, ev.mclk};
            diff  = longint'(ev.pts) - mclk;
            adiff = (diff < 0) ? -diff : diff;
            thr   = (ivl < longint'(cfg_model.max_sync)) ? ivl : longint'(cfg_model.max_sync);
            if (thr < longint'(cfg_model.min_sync))
                thr = longint'(cfg_model.min_sync);

            if (ev.mclk_ok && adiff < longint'(cfg_model.no_sync))
            begin
                if (diff <= -thr)
                    kind = RES_DROP;
                else if (diff >= thr)
                    ivl = ivl * 2;
            end

            if (kind == RES_RENDER)
            begin
                tmr = longint'(timer_q) + ivl;
                if (tmr > TIMER_MAX)
                    tmr = TIMER_MAX;
                timer_q = TIMER_W'(tmr);
                act = tmr - longint'(ev.now);
                if (act < longint'(cfg_model.min_delay))
                    act = longint'(cfg_model.min_delay);
                ms = (act + HALF_MS_US) / US_PER_MS;
                if (ms > MS_MAX)
                    ms = MS_MAX;
            end
        end

        d.eop    = (kind == RES_END);
        d.drop   = (kind == RES_DROP);
        d.render = (kind == RES_RENDER);
        d.ms     = (kind == RES_RENDER) ? MS_W'(ms) : '0;
        return d;
    endfunction

    // Send one refresh transaction, then maybe an idle burst
    task automatic send_refresh(refresh_t ev);
        int gap;
        in_valid           <= 1'b1;
        frame_present      <= ev.present;
        frame_pts_us       <= ev.pts;
        master_clock_us    <= ev.mclk;
        master_clock_valid <= ev.mclk_ok;
        now_us             <= ev.now;
        do @(posedge clk); while (!in_ready);
        expected_decisions.push_back(pace_event(ev));
        if (tx_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_fields(bit present, longint pts, longint mclk, bit mclk_ok,
                               longint now);
        refresh_t ev;
        ev.present = present;
        ev.pts     = PTS_W'(pts);
        ev.mclk    = MCLK_W'(mclk);
        ev.mclk_ok = mclk_ok;
        ev.now     = PTS_W'(now);
        send_refresh(ev);
    endtask

    // Hold the sender until every pending decision has come out
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (expected_decisions.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
    endtask

    task automatic apb_write(logic [RIDX_W-1:0] idx, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'({idx, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_pacer_config(afp_cfg_t c);
        apb_write(REG_MIN_SYNC,  PDATA_W'(c.min_sync));
        apb_write(REG_MAX_SYNC,  PDATA_W'(c.max_sync));
        apb_write(REG_NO_SYNC,   PDATA_W'(c.no_sync));
        apb_write(REG_MAX_GAP,   PDATA_W'(c.max_gap));
        apb_write(REG_MIN_DELAY, PDATA_W'(c.min_delay));
        cfg_model = c;
    endtask

    function automatic afp_cfg_t make_setting(longint min_s, longint max_s, longint no_s,
                                              longint gap, longint min_d);
        afp_cfg_t c;
        c.min_sync  = THR_W'(min_s);
        c.max_sync  = THR_W'(max_s);
        c.no_sync   = NOSYNC_W'(no_s);
        c.max_gap   = GAP_W'(gap);
        c.min_delay = DLY_W'(min_d);
        return c;
    endfunction

    function automatic longint clamp_time(longint v);
        if (v < 0)
            return 0;
        if (v > PTS_MAX)
            return PTS_MAX;
        return v;
    endfunction

    // Random settings: 0 near typical, 1 anywhere in range, 2 top of range,
    // 3 minimum threshold above maximum, 4 bottom of range
    function automatic afp_cfg_t pick_setting(int flavor);
        longint m;
        case (flavor)
            0: return make_setting($urandom_range(20000, 60000), $urandom_range(60000, 200000),
                                   $urandom_range(1000000, 20000000),
                                   $urandom_range(100000, 2000000), $urandom_range(0, 20000));
            1: return make_setting($urandom_range(0, 1000000), $urandom_range(0, 1000000),
                                   $urandom_range(0, 100000000), $urandom_range(1, 10000000),
                                   $urandom_range(0, 1000000));
            2: return make_setting(1000000, 1000000, 100000000, 10000000, 1000000);
            3:
            begin
                m = $urandom_range(50000, 300000);
                return make_setting(m, $urandom_range(0, m - 1), $urandom_range(1000000, 20000000),
                                    $urandom_range(100000, 2000000), $urandom_range(0, 20000));
            end
            default: return make_setting(0, 0, 0, 1, 0);
        endcase
    endfunction

    // Random event mix: mostly steady frame streams, plus end-of-play,
    // raw noise and broken timestamp sequences
    task automatic run_stream_items(int count, bit with_idle);
        refresh_t    ev;
        logic [63:0] rw;
        longint      base;
        longint      step;
        longint      pts;
        longint      diff;
        longint      nowv;
        longint      sgn;
        longint      gap;
        int          pick;
        for (int i = 0; i < count; i++)
        begin
            // idling comes and goes in stretches
            if (i % 40 == 0)
            begin
                tx_idle_en = with_idle && ($urandom_range(0, 3) != 0);
                rx_idle_en = with_idle && ($urandom_range(0, 3) != 0);
            end
            if (i == count / 2)
                wait_results_done();

            gap  = longint'(cfg_model.max_gap);
            base = longint'(last_pts_q);
            if (base > (longint'(1) <<< 39))
                base = longint'($urandom_range(0, 1000000));
            sgn  = ($urandom_range(0, 1) != 0) ? 1 : -1;
            pick = $urandom_range(0, 99);

            if (pick < 6)
            begin
                // no frame waiting; other fields are don't-care
                rw = {$urandom, $urandom};
                ev.present = 1'b0;
                ev.pts     = rw[PTS_W-1:0];
                rw = {$urandom, $urandom};
                ev.mclk    = rw[MCLK_W-1:0];
                ev.mclk_ok = rw[63];
                rw = {$urandom, $urandom};
                ev.now     = rw[PTS_W-1:0];
            end
            else if (pick < 12)
            begin
                rw = {$urandom, $urandom};
                ev.present = 1'b1;
                ev.pts     = rw[PTS_W-1:0];
                rw = {$urandom, $urandom};
                ev.mclk    = rw[MCLK_W-1:0];
                ev.mclk_ok = rw[63];
                rw = {$urandom, $urandom};
                ev.now     = rw[PTS_W-1:0];
            end
            else if (pick < 16)
            begin
                // broken timestamps: repeat, step back, gap at the limit, restart
                case ($urandom_range(0, 3))
                    0: pts = base;
                    1: pts = clamp_time(base - longint'($urandom_range(1, 500000)));
                    2: pts = base + gap;
                    default: pts = 0;
                endcase
                ev.present = 1'b1;
                ev.pts     = PTS_W'(pts);
                ev.mclk    = MCLK_W'(pts);
                ev.mclk_ok = ($urandom_range(0, 1) != 0);
                ev.now     = PTS_W'(clamp_time(longint'(timer_q)));
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: step = 16667;
                    1: step = 33333;
                    2: step = 40000;
                    3: step = 41708;
                    4: step = longint'($urandom_range(1, 120000));
                    default: step = gap - 1 + longint'($urandom_range(0, 2));
                endcase
                pts = base + step;
                // clock offset, often right at a threshold edge
                case ($urandom_range(0, 9))
                    5: diff = sgn * longint'(cfg_model.min_sync);
                    6: diff = sgn * longint'(cfg_model.max_sync);
                    7: diff = sgn * (longint'(cfg_model.min_sync) + sgn);
                    8: diff = sgn * longint'($urandom_range(0, 2100000));
                    9: diff = sgn * (longint'(cfg_model.no_sync) - longint'($urandom_range(0, 1)));
                    default: diff = longint'($urandom_range(0, 20000)) - 10000;
                endcase
                case ($urandom_range(0, 7))
                    0: nowv = longint'(timer_q) - longint'($urandom_range(0, 70000000));
                    1: nowv = longint'(timer_q) + longint'($urandom_range(0, 200000));
                    default: nowv = longint'(timer_q) + step - longint'($urandom_range(0, 120000));
                endcase
                ev.present = 1'b1;
                ev.pts     = PTS_W'(pts);
                ev.mclk    = MCLK_W'(pts - diff);
                ev.mclk_ok = ($urandom_range(0, 15) != 0);
                ev.now     = PTS_W'(clamp_time(nowv));
            end
            send_refresh(ev);
        end
    endtask

    // Reset values, first frames, gap fallback, drop/double edges
    task automatic test_defaults_directed();
        send_fields(1'b0, PTS_MAX, MCLK_MIN, 1'b1, PTS_MAX);
        send_fields(1'b1, 0, 0, 1'b1, 0);
        send_fields(1'b1, 33333, 33333, 1'b1, 0);
        send_fields(1'b1, 66666, 66666, 1'b1, longint'(timer_q));
        // diff exactly at minus threshold drops
        send_fields(1'b1, 100000, 140000, 1'b1, longint'(timer_q));
        send_fields(1'b1, 133333, 173332, 1'b1, longint'(timer_q));
        // diff exactly at threshold doubles
        send_fields(1'b1, 166666, 126666, 1'b1, longint'(timer_q));
        // offset equal to the no-sync limit: no correction
        send_fields(1'b1, 200000, 200000 - 10000000, 1'b1, longint'(timer_q));
        send_fields(1'b1, 233333, 0, 1'b0, longint'(timer_q));
        // gap at and just below the maximum
        send_fields(1'b1, 1233333, 1233333, 1'b1, longint'(timer_q));
        send_fields(1'b1, 2233332, 2233332, 1'b1, longint'(timer_q));
        // timestamp going back, then repeated
        send_fields(1'b1, 5000, 5000, 1'b1, longint'(timer_q));
        send_fields(1'b1, 5000, 5000, 1'b1, longint'(timer_q));
        // late wake-up hits the delay floor
        send_fields(1'b1, 38333, 38333, 1'b1, longint'(timer_q) + 1000000);
        send_fields(1'b1, PTS_MAX, MCLK_MIN, 1'b1, PTS_MAX);
    endtask

    // Half-up rounding and the floor on the delay
    task automatic test_delay_rounding();
        wait_results_done();
        write_pacer_config(make_setting(40000, 100000, 10000000, 1000000, 0));
        send_fields(1'b1, 1000000, 0, 1'b0, PTS_MAX);
        send_fields(1'b1, 1030000, 0, 1'b0, longint'(timer_q) + 30000 - 2500);
        send_fields(1'b1, 1060000, 0, 1'b0, longint'(timer_q) + 30000 - 2499);
        wait_results_done();
        write_pacer_config(make_setting(40000, 100000, 10000000, 1000000, 1500));
        send_fields(1'b1, 1090000, 0, 1'b0, PTS_MAX);
    endtask

    // Minimum threshold above the maximum: the minimum wins
    task automatic test_threshold_order();
        wait_results_done();
        write_pacer_config(make_setting(90000, 50000, 10000000, 1000000, 10000));
        send_fields(1'b1, 1120000, 0, 1'b0, longint'(timer_q));
        send_fields(1'b1, 1150000, 1150000 + 89999, 1'b1, longint'(timer_q));
        send_fields(1'b1, 1180000, 1180000 + 90000, 1'b1, longint'(timer_q));
    endtask

    // Large doubled intervals push the delay past the 16-bit millisecond range
    task automatic test_delay_saturation();
        wait_results_done();
        write_pacer_config(make_setting(0, 1000000, 100000000, 10000000, 1000000));
        for (int i = 0; i < 5; i++)
            send_fields(1'b1, 2000000 + i * 9999999, i * 9999999, 1'b1, 0);
    endtask

    // Random streams across several register settings, with idling
    task automatic test_random_streams();
        for (int p = 0; p < 5; p++)
        begin
            wait_results_done();
            write_pacer_config(pick_setting(p));
            run_stream_items(225, 1'b1);
        end
    endtask

    // Back-to-back transactions with both sides always ready
    task automatic test_full_rate();
        wait_results_done();
        write_pacer_config(pick_setting(0));
        run_stream_items(225, 1'b0);
        wait_results_done();
    endtask

    // Result side: random stall bursts while enabled
    initial
    begin
        out_ready <= 1'b0;
        rx_hold = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold != 0)
            begin
                rx_hold--;
                out_ready <= 1'b0;
            end
            else if (rx_idle_en && $urandom_range(0, 5) == 0)
            begin
                rx_hold = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin : check_results
        decision_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_decisions.size() == 0)
                report_error("result transaction with nothing pending");
            else
            begin
                want = expected_decisions.pop_front();
                if (end_of_play !== want.eop)
                    report_error($sformatf("end_of_play: expected %0d, got %0d",
                                           want.eop, end_of_play));
                if (drop_frame !== want.drop)
                    report_error($sformatf("drop_frame: expected %0d, got %0d",
                                           want.drop, drop_frame));
                if (render_frame !== want.render)
                    report_error($sformatf("render_frame: expected %0d, got %0d",
                                           want.render, render_frame));
                if (next_delay_ms !== want.ms)
                    report_error($sformatf("next_delay_ms: expected %0d, got %0d",
                                           want.ms, next_delay_ms));
            end
        end
    end

    // Sequence
    initial
    begin
        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        in_valid           <= 1'b0;
        frame_present      <= 1'b0;
        frame_pts_us       <= '0;
        master_clock_us    <= '0;
        master_clock_valid <= 1'b0;
        now_us             <= '0;
        cycle_count        = 0;
        mismatch_count     = 0;
        cfg_model  = make_setting(MIN_SYNC_RST, MAX_SYNC_RST, NO_SYNC_RST, MAX_GAP_RST,
                                  MIN_DELAY_RST);
        last_pts_q = '0;
        last_ivl_q = 0;
        timer_q    = '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults_directed();
        test_delay_rounding();
        test_threshold_order();
        test_delay_saturation();
        test_random_streams();
        test_full_rate();

        repeat (PIPE_LATENCY + 4) @(posedge clk);
        if (mismatch_count == 0 && expected_decisions.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/afp_pkg.sv
hw/rtl/afp_cfg_regs.sv
hw/rtl/afp_decide.sv
hw/rtl/afp_delay.sv
hw/rtl/av_sync_frame_pacer.sv
verif/tb_av_sync_frame_pacer.sv
